/* rtl/core/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and the controller state type for the prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Default width of the tested value.
  localparam int unsigned ValueBitsDefault = 31;

  // Width of the result field.
  localparam int unsigned PrimeBits = 1;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StBound,
    StDivide,
    StDone
  } state_e;

endpackage : tdpt_pkg

/* rtl/core/trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// Trial division prime test
// Reports whether an unsigned integer is prime by bit-serial trial division.
// ----------------------------------------------------------------------------
// Usage:
// One value enters per slave transaction (s_axis_*), and exactly one verdict
// leaves per master transaction (m_axis_*). The verdict is 1 when no divisor
// d with 2 <= d and d*d <= value divides the value, so 0 and 1 report prime.
// Even values are settled by their lowest bit; odd values are tried against
// the odd divisors 3, 5, 7, ... while d*d <= value. Each trial is a restoring
// division that shifts in one bit of the value per cycle; a trial is one
// bound check plus VALUE_BITS remainder steps. Values below four and even
// values go from idle straight to the done state; odd values alternate bound
// checks and remainder loops until a divisor divides the value or d*d
// exceeds it, and then pass to the done state as well.
// The block works on one value at a time; s_axis_tready_o is high while it
// is idle. The verdict sits in an output register, so a new value is taken
// while a finished verdict still waits for the receiver. If the receiver
// stalls and the next verdict is ready, the block holds it until the output
// register frees. Reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int unsigned VALUE_BITS = tdpt_pkg::ValueBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0 up: value [VALUE_BITS-1:0], zero padding to whole bytes.
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata_i,
  // Result stream.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // Fields from bit 0 up: is_prime [0], zero padding to bits [7:1].
  output logic [7:0]                          m_axis_tdata_o
);

  localparam int unsigned SqBits  = VALUE_BITS + 2;
  localparam int unsigned CntBits = $clog2(VALUE_BITS);

  tdpt_pkg::state_e state_q, state_d;

  // Working registers of the current value.
  logic [VALUE_BITS-1:0] val_q, val_d;       // value under test
  logic [VALUE_BITS-1:0] shift_q, shift_d;   // value bits, MSB shifted out first
  logic [VALUE_BITS-1:0] rem_q, rem_d;       // partial remainder
  logic [VALUE_BITS-1:0] div_q, div_d;       // current odd divisor
  logic [SqBits-1:0]     sq_q, sq_d;         // square of the current divisor
  logic [CntBits-1:0]    cnt_q, cnt_d;       // remainder step counter
  logic                  verdict_q, verdict_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic                  out_prime_q, out_prime_d;

  // Remainder step.
  logic [VALUE_BITS:0]   rem_shift;
  logic                  rem_ge;
  logic [VALUE_BITS-1:0] rem_next;

  logic                  in_fire;
  logic                  out_free;
  logic                  bound_exceeded;
  logic                  last_step;
  logic [VALUE_BITS-1:0] in_value;

  assign in_value        = s_axis_tdata_i[VALUE_BITS-1:0];
  assign s_axis_tready_o = (state_q == tdpt_pkg::StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign bound_exceeded  = sq_q > {2'b00, val_q};
  assign last_step       = (cnt_q == CntBits'(VALUE_BITS - 1));

  assign rem_shift = {rem_q, shift_q[VALUE_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_q};
  assign rem_next  = rem_ge ? VALUE_BITS'(rem_shift - {1'b0, div_q})
                            : rem_shift[VALUE_BITS-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdpt_pkg::StIdle: begin
        if (in_fire) begin
          if (in_value < VALUE_BITS'(4) || !in_value[0]) begin
            state_d = tdpt_pkg::StDone;
          end else begin
            state_d = tdpt_pkg::StBound;
          end
        end
      end
      tdpt_pkg::StBound: begin
        state_d = bound_exceeded ? tdpt_pkg::StDone : tdpt_pkg::StDivide;
      end
      tdpt_pkg::StDivide: begin
        if (last_step) begin
          state_d = (rem_next == '0) ? tdpt_pkg::StDone : tdpt_pkg::StBound;
        end
      end
      tdpt_pkg::StDone: begin
        if (out_free) begin
          state_d = tdpt_pkg::StIdle;
        end
      end
      default: state_d = tdpt_pkg::StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    val_d       = val_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    div_d       = div_q;
    sq_d        = sq_q;
    cnt_d       = cnt_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tdpt_pkg::StIdle: begin
        if (in_fire) begin
          val_d = in_value;
          // Values below four are prime by definition here; other even
          // values have two as a divisor.
          verdict_d = (in_value < VALUE_BITS'(4)) || in_value[0];
          div_d     = VALUE_BITS'(3);
          sq_d      = SqBits'(9);
        end
      end
      tdpt_pkg::StBound: begin
        if (bound_exceeded) begin
          verdict_d = 1'b1;
        end else begin
          shift_d = val_q;
          rem_d   = '0;
          cnt_d   = '0;
        end
      end
      tdpt_pkg::StDivide: begin
        rem_d   = rem_next;
        shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
        cnt_d   = cnt_q + CntBits'(1);
        if (last_step) begin
          if (rem_next == '0) begin
            verdict_d = 1'b0;
          end else begin
            // (d + 2)^2 = d^2 + 4 * (d + 1).
            sq_d  = sq_q + {2'b00, div_q + VALUE_BITS'(1)} * SqBits'(4);
            div_d = div_q + VALUE_BITS'(2);
          end
        end
      end
      tdpt_pkg::StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_prime_d = verdict_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    shift_q     <= shift_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    verdict_q   <= verdict_d;
    out_prime_q <= out_prime_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(8 - tdpt_pkg::PrimeBits)'(0), out_prime_q};

endmodule : trial_division_prime_test

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Trial division prime test bench
// Drives values into the prime tester over its input stream and checks each
// verdict against an in-bench trial division. Directed corners, a filled
// pipeline under a long output hold-off, and random traffic with idle and
// stall phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned ValueBits = tdpt_pkg::ValueBitsDefault;
  localparam int unsigned DataBits  = ((ValueBits + 7) / 8) * 8;

  // The worst single value is the largest field value, itself prime. Random
  // values are mostly small or carry a small factor, so all items together
  // stay well short of the limit even with every stall. The limit is several
  // times the slowest correct run.
  localparam int unsigned CycleLimit = 5_000_000;

  // Cycles the receiver keeps its ready low during the fill test. Far longer
  // than two small values need, so the block fills and stalls its input.
  localparam int unsigned HoldOffCycles = 2000;

  // Cycles allowed after the last verdict before the final decision.
  localparam int unsigned SettleCycles = 16;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 is_prime;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [DataBits-1:0] s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [7:0]          m_axis_tdata_o;

  // Verdicts predicted for accepted values, oldest first.
  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  // Written by a test to start a hold-off; the ready process counts it down.
  int unsigned hold_request    = 0;

  trial_division_prime_test #(
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Trial division on the value field only. Bits above the field are dropped,
  // values below four are prime, even values above that are not, and odd
  // values are tried against odd divisors while d <= n / d, which is the
  // same bound as d * d <= n without any overflow.
  function automatic logic prime_verdict(input logic [DataBits-1:0] word);
    longint unsigned n;
    longint unsigned d;
    n = word[ValueBits-1:0];
    if (n < 4) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Offers one value and returns at the clock edge where the transaction
  // completes. Valid stays high on return so that back-to-back values need
  // no low pulse; an idle gap or the drain lowers it in a later step.
  task automatic send_value(input logic [DataBits-1:0] word);
    verdict_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    entry.value    = word[ValueBits-1:0];
    entry.is_prime = prime_verdict(word);
    pending_verdicts.push_back(entry);
  endtask

  // The sender stays quiet until every predicted verdict has arrived.
  task automatic wait_all_verdicts();
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Mostly small values so the bound loop stays short, plus large even values
  // and large multiples of a small odd factor that reach the high bits yet
  // finish fast, and now and then a medium value that runs a longer loop.
  function automatic logic [DataBits-1:0] random_value();
    int unsigned pick;
    int unsigned factor;
    logic [DataBits-1:0] word;
    pick = $urandom_range(99);
    if (pick < 55) begin
      word = $urandom_range(4095);
    end else if (pick < 70) begin
      word = $urandom_range(2047) * 2 + 1;
    end else if (pick < 80) begin
      word = $urandom() & 32'h7FFF_FFFE;
    end else if (pick < 92) begin
      factor = $urandom_range(31) * 2 + 3;
      word   = factor * $urandom_range(32'h7FFF_FFFF / factor);
    end else begin
      word = $urandom_range((1 << 20) - 1);
    end
    return word;
  endfunction

  // Field extremes, the values below four, squares of primes that sit right
  // on the bound, a product of two primes near each other, the largest field
  // value (prime, so the longest run) and a word with a padding bit set.
  task automatic test_directed_corners();
    logic [DataBits-1:0] corners[22];
    corners = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd15, 32'd25,
      32'd49, 32'd97, 32'd121, 32'd65537, 32'd1052651, 32'h4000_0000,
      32'h2AAA_AAAA, 32'h5555_5555, 32'd2147483645, 32'd2147483646,
      32'h8000_0007, 32'd2147483647
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corners[i]) send_value(corners[i]);
    wait_all_verdicts();
  endtask

  // The receiver holds off long enough that one verdict waits in the output
  // register, the next one finishes behind it, and the input stalls.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HoldOffCycles;
    repeat (8) send_value($urandom_range(255));
    wait_all_verdicts();
  endtask

  task automatic test_random_traffic(input int unsigned count,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_value(random_value());
    wait_all_verdicts();
  endtask

  // Result ready: a counted hold-off when one is requested, else random
  // stalls at the current rate.
  initial begin : drive_result_ready
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Each completed result transaction is matched against the oldest
  // predicted verdict. Values are sampled at the edge, before any update.
  always @(posedge clk_i) begin : check_verdicts
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0b with no value outstanding",
                                  m_axis_tdata_o[0]));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata_o[0] !== want.is_prime) begin
          report_mismatch($sformatf("value %0d: is_prime %b, want %b",
                                    want.value, m_axis_tdata_o[0], want.is_prime));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_output_backpressure();
    test_random_traffic(18, 0, 0);
    test_random_traffic(18, 64, 0);
    test_random_traffic(18, 0, 64);
    test_random_traffic(18, 28, 28);

    // Give a stray extra verdict time to show up before deciding.
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : tb_top
